// File: hw/rtl/stt_pkg.sv
// Package for the software timer table: table size, item and result codes,
// sequencer states and the timer memory write request.
// No dependencies.
package stt_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_CONFIG = 3'd2,
    KIND_FREE   = 3'd3,
    KIND_SCAN   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RES_ALLOCATED = 2'd0,
    RES_FULL      = 2'd1,
    RES_EXPIRY    = 2'd2,
    RES_DONE      = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_SCAN_DONE
  } state_e;

  typedef struct packed {
    logic              en;
    logic              period_en;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       period;
    logic [31:0]       start;
  } mem_wr_t;

endpackage

// File: hw/rtl/stt_timer_mem.sv
// Period and start-time storage of the timer table, one write port and one
// registered read port. Depends on stt_pkg.
module stt_timer_mem (
  input  logic                   clk_i,
  input  stt_pkg::mem_wr_t       wr_i,
  input  logic                   rd_en_i,
  input  logic [stt_pkg::SLOT_W-1:0] rd_addr_i,
  output logic [31:0]            rd_period_o,
  output logic [31:0]            rd_start_o
);
  import stt_pkg::*;

  logic [31:0] period_mem [NUM_SLOTS];
  logic [31:0] start_mem  [NUM_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      start_mem[wr_i.addr] <= wr_i.start;
      if (wr_i.period_en) begin
        period_mem[wr_i.addr] <= wr_i.period;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_period_o <= period_mem[rd_addr_i];
      rd_start_o  <= start_mem[rd_addr_i];
    end
  end

endmodule

// File: hw/rtl/software_timer_table.sv
// Software timer table: top level with the slot sequencer, slot flags, tick
// counter and output register. Depends on stt_pkg and stt_timer_mem.
//
// A tick, configure or free transfer is taken in ST_IDLE and leaves the input
// ready. After its transfer an allocate sweeps the in-use flags from slot 0
// one slot per cycle and stalls the input until it finds the first free slot
// or the table is full, plus any output stall. A scan visits every slot once:
// an inactive slot takes a read state only, an active one a read state and an
// evaluate state (memory read, then the shared subtract and compare against
// its period), and the done result its own state; the input stays stalled
// throughout, plus any output stall. The single read port of the period/start
// memory is why an active slot needs both states. The memory needs no
// clearing pass after reset: an entry is read only while its slot is active,
// and only a configure makes a slot active and writes both words.
module software_timer_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // slot[4:0], period[36:5], repeat_mode[37], start_active[38], has_handler[39]
  input  logic [stt_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // slot_index[4:0], now_count[36:5], zero padding[39:37]
  output logic [stt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // result_kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import stt_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [31:0]       tick_count_q;

  logic [NUM_SLOTS-1:0] in_use_q, active_q, periodic_q, handler_q;

  logic        out_valid_q;
  res_kind_e   out_kind_q, out_kind_d;
  logic [4:0]  out_slot_q, out_slot_d;
  logic        out_last_q, out_last_d;
  logic [31:0] out_now_q;
  logic        out_free, load_out;

  logic        acc;
  kind_e       in_kind;
  logic [4:0]  in_slot;
  logic [31:0] in_period;
  logic        in_repeat, in_act, in_hand, slot_ok;
  logic [SLOT_W-1:0] in_addr;

  mem_wr_t     wr;
  logic        rd_en;
  logic [31:0] rd_period, rd_start;
  logic [31:0] elapsed, new_start;
  logic        expired;
  logic        alloc_claim, expire_clear;

  assign acc       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_kind   = kind_e'(s_axis_tuser_i);
  assign in_slot   = s_axis_tdata_i[4:0];
  assign in_period = s_axis_tdata_i[36:5];
  assign in_repeat = s_axis_tdata_i[37];
  assign in_act    = s_axis_tdata_i[38];
  assign in_hand   = s_axis_tdata_i[39];
  assign slot_ok   = {1'b0, in_slot} < 6'(NUM_SLOTS);
  assign in_addr   = in_slot[SLOT_W-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Shared evaluation unit: wrapping elapsed time against the period.
  assign elapsed   = tick_count_q - rd_start;
  assign expired   = (elapsed >= rd_period);
  assign new_start = rd_start + rd_period;

  stt_timer_mem u_mem (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q),
    .rd_period_o(rd_period),
    .rd_start_o (rd_start)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    load_out     = 1'b0;
    out_kind_d   = RES_DONE;
    out_slot_d   = 5'(idx_q);
    out_last_d   = 1'b1;
    alloc_claim  = 1'b0;
    expire_clear = 1'b0;
    rd_en        = 1'b0;
    wr           = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_ALLOC: begin
              idx_d   = '0;
              state_d = ST_ALLOC;
            end
            KIND_CONFIG: begin
              if (slot_ok) begin
                wr.en        = 1'b1;
                wr.period_en = 1'b1;
                wr.addr      = in_addr;
                wr.period    = in_period;
                wr.start     = in_act ? tick_count_q : 32'd0;
              end
            end
            KIND_SCAN: begin
              idx_d   = '0;
              state_d = ST_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      ST_ALLOC: begin
        if (!in_use_q[idx_q]) begin
          if (out_free) begin
            load_out    = 1'b1;
            out_kind_d  = RES_ALLOCATED;
            alloc_claim = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (idx_q == LAST_IDX) begin
          if (out_free) begin
            load_out   = 1'b1;
            out_kind_d = RES_FULL;
            out_slot_d = 5'd0;
            state_d    = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN_RD: begin
        if (active_q[idx_q]) begin
          rd_en   = 1'b1;
          state_d = ST_SCAN_EVAL;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_SCAN_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN_EVAL: begin
        // An event that cannot be placed yet holds the slot untouched.
        if (!(expired && handler_q[idx_q] && !out_free)) begin
          if (expired) begin
            if (periodic_q[idx_q]) begin
              wr.en    = 1'b1;
              wr.addr  = idx_q;
              wr.start = new_start;
            end else begin
              expire_clear = 1'b1;
            end
            if (handler_q[idx_q]) begin
              load_out   = 1'b1;
              out_kind_d = RES_EXPIRY;
              out_last_d = 1'b0;
            end
          end
          if (idx_q == LAST_IDX) begin
            state_d = ST_SCAN_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_kind_d = RES_DONE;
          out_slot_d = 5'd0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      in_use_q     <= '0;
      active_q     <= '0;
      periodic_q   <= '0;
      handler_q    <= '0;
    end else begin
      if (acc && in_kind == KIND_TICK) begin
        tick_count_q <= tick_count_q + 32'd1;
      end
      if (acc && in_kind == KIND_CONFIG && slot_ok) begin
        active_q[in_addr]   <= in_act;
        periodic_q[in_addr] <= in_repeat;
        handler_q[in_addr]  <= in_hand;
      end
      if (acc && in_kind == KIND_FREE && slot_ok) begin
        in_use_q[in_addr]   <= 1'b0;
        active_q[in_addr]   <= 1'b0;
        periodic_q[in_addr] <= 1'b0;
        handler_q[in_addr]  <= 1'b0;
      end
      if (alloc_claim) begin
        in_use_q[idx_q] <= 1'b1;
      end
      if (expire_clear) begin
        in_use_q[idx_q]   <= 1'b0;
        active_q[idx_q]   <= 1'b0;
        periodic_q[idx_q] <= 1'b0;
        handler_q[idx_q]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= out_slot_d;
      out_last_q <= out_last_d;
      out_now_q  <= tick_count_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_now_q, out_slot_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // Only the scan done, allocate and table full results close an item.
  a_expiry_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == RES_EXPIRY |-> !m_axis_tlast_o)
    else $error("expiry event marked as last transfer");

  // A slot under evaluation was active when its memory read was issued.
  a_eval_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_EVAL |-> active_q[idx_q])
    else $error("evaluating an inactive slot");

  a_tick_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_kind == KIND_TICK |=> tick_count_q == $past(tick_count_q) + 32'd1)
    else $error("tick transfer did not advance the counter");

  a_scan_no_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_RD || state_q == ST_SCAN_EVAL) |-> !s_axis_tready_o)
    else $error("input accepted during a scan");

endmodule
